FILE: hw/rtl/icp_pkg.sv
// Shared types, constants and lookup functions of the text cell parser.
`default_nettype none
package icp_pkg;

	localparam logic [1:0] KIND_GLYPH   = 2'd0;
	localparam logic [1:0] KIND_EOL     = 2'd1;
	localparam logic [1:0] KIND_EOL_FUL = 2'd2;

	localparam logic [1:0] REG_ROW_LIMIT   = 2'd0;
	localparam logic [1:0] REG_USE_DEFAULT = 2'd1;
	localparam logic [1:0] REG_PAL0        = 2'd2;
	localparam logic [1:0] REG_PAL1        = 2'd3;

	localparam logic [7:0] CH_NUL   = 8'd0;
	localparam logic [7:0] CH_BOLD  = 8'd2;
	localparam logic [7:0] CH_COLOR = 8'd3;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_PLAIN = 8'd15;
	localparam logic [7:0] CH_REV   = 8'd22;
	localparam logic [7:0] CH_ITAL  = 8'd29;
	localparam logic [7:0] CH_UNDER = 8'd31;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [20:0] BLOCK_LO = 21'h2580;
	localparam logic [20:0] BLOCK_HI = 21'h259F;

	// Classified word passed from the front part to the back part.
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  glyph;
		logic        bank;
		logic [9:0]  column;
		logic [7:0]  row;
		logic [6:0]  fg_idx;
		logic [6:0]  bg_idx;
	} cell_word_t;

	typedef struct packed {
		logic [7:0]  row_limit;
		logic        use_default;
		logic [23:0] pal0;
		logic [23:0] pal1;
	} cfg_t;

	function automatic logic [23:0] pal_fixed(input logic [6:0] i);
		logic [23:0] r;
		case (i)
			7'd2: r = 24'h00007F; 7'd3: r = 24'h009300; 7'd4: r = 24'hFF0000;
			7'd5: r = 24'h7F0000; 7'd6: r = 24'h9C009C; 7'd7: r = 24'hFC7F00;
			7'd8: r = 24'hFFFF00; 7'd9: r = 24'h00FC00; 7'd10: r = 24'h009393;
			7'd11: r = 24'h00FFFF; 7'd12: r = 24'h0000FC; 7'd13: r = 24'hFF00FF;
			7'd14: r = 24'h7F7F7F; 7'd15: r = 24'hD2D2D2; 7'd16: r = 24'h470000;
			7'd17: r = 24'h472100; 7'd18: r = 24'h474700; 7'd19: r = 24'h324700;
			7'd20: r = 24'h004700; 7'd21: r = 24'h00472C; 7'd22: r = 24'h004747;
			7'd23: r = 24'h002747; 7'd24: r = 24'h000047; 7'd25: r = 24'h2E0047;
			7'd26: r = 24'h470047; 7'd27: r = 24'h47002A; 7'd28: r = 24'h740000;
			7'd29: r = 24'h743A00; 7'd30: r = 24'h747400; 7'd31: r = 24'h517400;
			7'd32: r = 24'h007400; 7'd33: r = 24'h007449; 7'd34: r = 24'h007474;
			7'd35: r = 24'h004074; 7'd36: r = 24'h000074; 7'd37: r = 24'h4B0074;
			7'd38: r = 24'h740074; 7'd39: r = 24'h740045; 7'd40: r = 24'hB50000;
			7'd41: r = 24'hB56300; 7'd42: r = 24'hB5B500; 7'd43: r = 24'h7DB500;
			7'd44: r = 24'h00B500; 7'd45: r = 24'h00B571; 7'd46: r = 24'h00B5B5;
			7'd47: r = 24'h0063B5; 7'd48: r = 24'h0000B5; 7'd49: r = 24'h7500B5;
			7'd50: r = 24'hB500B5; 7'd51: r = 24'hB5006B; 7'd52: r = 24'hFF0000;
			7'd53: r = 24'hFF8C00; 7'd54: r = 24'hFFFF00; 7'd55: r = 24'hB2FF00;
			7'd56: r = 24'h00FF00; 7'd57: r = 24'h00FFA0; 7'd58: r = 24'h00FFFF;
			7'd59: r = 24'h008CFF; 7'd60: r = 24'h0000FF; 7'd61: r = 24'hA500FF;
			7'd62: r = 24'hFF00FF; 7'd63: r = 24'hFF0098; 7'd64: r = 24'hFF5959;
			7'd65: r = 24'hFFB459; 7'd66: r = 24'hFFFF71; 7'd67: r = 24'hCFFF60;
			7'd68: r = 24'h6FFF6F; 7'd69: r = 24'h65FFC9; 7'd70: r = 24'h6DFFFF;
			7'd71: r = 24'h59B4FF; 7'd72: r = 24'h5959FF; 7'd73: r = 24'hC459FF;
			7'd74: r = 24'hFF66FF; 7'd75: r = 24'hFF59BC; 7'd76: r = 24'hFF9C9C;
			7'd77: r = 24'hFFD39C; 7'd78: r = 24'hFFFF9C; 7'd79: r = 24'hE2FF9C;
			7'd80: r = 24'h9CFF9C; 7'd81: r = 24'h9CFFDB; 7'd82: r = 24'h9CFFFF;
			7'd83: r = 24'h9CD3FF; 7'd84: r = 24'h9C9CFF; 7'd85: r = 24'hDC9CFF;
			7'd86: r = 24'hFF9CFF; 7'd87: r = 24'hFF94D3; 7'd88: r = 24'h000000;
			7'd89: r = 24'h131313; 7'd90: r = 24'h282828; 7'd91: r = 24'h363636;
			7'd92: r = 24'h4D4D4D; 7'd93: r = 24'h656565; 7'd94: r = 24'h818181;
			7'd95: r = 24'h9F9F9F; 7'd96: r = 24'hBCBCBC; 7'd97: r = 24'hE2E2E2;
			7'd98: r = 24'hFFFFFF;
			default: r = 24'h000000;
		endcase
		return r;
	endfunction

	// Code page 437 glyph for a code point; low byte when the code point is not in the table.
	function automatic logic [7:0] to_cp437(input logic [20:0] cp);
		logic [7:0] g;
		g = cp[7:0];
		if (cp[20:16] == 5'd0) begin
			case (cp[15:0])
				16'h00C7: g = 8'h80; 16'h00FC: g = 8'h81; 16'h00E9: g = 8'h82;
				16'h00E2: g = 8'h83; 16'h00E4: g = 8'h84; 16'h00E0: g = 8'h85;
				16'h00E5: g = 8'h86; 16'h00E7: g = 8'h87; 16'h00EA: g = 8'h88;
				16'h00EB: g = 8'h89; 16'h00E8: g = 8'h8A; 16'h00EF: g = 8'h8B;
				16'h00EE: g = 8'h8C; 16'h00EC: g = 8'h8D; 16'h00C4: g = 8'h8E;
				16'h00C5: g = 8'h8F; 16'h00C9: g = 8'h90; 16'h00E6: g = 8'h91;
				16'h00C6: g = 8'h92; 16'h00F4: g = 8'h93; 16'h00F6: g = 8'h94;
				16'h00F2: g = 8'h95; 16'h00FB: g = 8'h96; 16'h00F9: g = 8'h97;
				16'h00FF: g = 8'h98; 16'h00D6: g = 8'h99; 16'h00DC: g = 8'h9A;
				16'h00A2: g = 8'h9B; 16'h00A3: g = 8'h9C; 16'h00A5: g = 8'h9D;
				16'h20A7: g = 8'h9E; 16'h0192: g = 8'h9F; 16'h00E1: g = 8'hA0;
				16'h00ED: g = 8'hA1; 16'h00F3: g = 8'hA2; 16'h00FA: g = 8'hA3;
				16'h00F1: g = 8'hA4; 16'h00D1: g = 8'hA5; 16'h00AA: g = 8'hA6;
				16'h00BA: g = 8'hA7; 16'h00BF: g = 8'hA8; 16'h2310: g = 8'hA9;
				16'h00AC: g = 8'hAA; 16'h00BD: g = 8'hAB; 16'h00BC: g = 8'hAC;
				16'h00A1: g = 8'hAD; 16'h00AB: g = 8'hAE; 16'h00BB: g = 8'hAF;
				16'h2591: g = 8'hB0; 16'h2592: g = 8'hB1; 16'h2593: g = 8'hB2;
				16'h2502: g = 8'hB3; 16'h2524: g = 8'hB4; 16'h2561: g = 8'hB5;
				16'h2562: g = 8'hB6; 16'h2556: g = 8'hB7; 16'h2555: g = 8'hB8;
				16'h2563: g = 8'hB9; 16'h2551: g = 8'hBA; 16'h2557: g = 8'hBB;
				16'h255D: g = 8'hBC; 16'h255C: g = 8'hBD; 16'h255B: g = 8'hBE;
				16'h2510: g = 8'hBF; 16'h2514: g = 8'hC0; 16'h2534: g = 8'hC1;
				16'h252C: g = 8'hC2; 16'h251C: g = 8'hC3; 16'h2500: g = 8'hC4;
				16'h253C: g = 8'hC5; 16'h255E: g = 8'hC6; 16'h255F: g = 8'hC7;
				16'h255A: g = 8'hC8; 16'h2554: g = 8'hC9; 16'h2569: g = 8'hCA;
				16'h2566: g = 8'hCB; 16'h2560: g = 8'hCC; 16'h2550: g = 8'hCD;
				16'h256C: g = 8'hCE; 16'h2567: g = 8'hCF; 16'h2568: g = 8'hD0;
				16'h2564: g = 8'hD1; 16'h2565: g = 8'hD2; 16'h2559: g = 8'hD3;
				16'h2558: g = 8'hD4; 16'h2552: g = 8'hD5; 16'h2553: g = 8'hD6;
				16'h256B: g = 8'hD7; 16'h256A: g = 8'hD8; 16'h2518: g = 8'hD9;
				16'h250C: g = 8'hDA; 16'h2588: g = 8'hDB; 16'h2584: g = 8'hDC;
				16'h258C: g = 8'hDD; 16'h2590: g = 8'hDE; 16'h2580: g = 8'hDF;
				16'h03B1: g = 8'hE0; 16'h00DF: g = 8'hE1; 16'h0393: g = 8'hE2;
				16'h03C0: g = 8'hE3; 16'h03A3: g = 8'hE4; 16'h03C3: g = 8'hE5;
				16'h00B5: g = 8'hE6; 16'h03C4: g = 8'hE7; 16'h03A6: g = 8'hE8;
				16'h0398: g = 8'hE9; 16'h03A9: g = 8'hEA; 16'h03B4: g = 8'hEB;
				16'h221E: g = 8'hEC; 16'h03C6: g = 8'hED; 16'h03B5: g = 8'hEE;
				16'h2229: g = 8'hEF; 16'h2261: g = 8'hF0; 16'h00B1: g = 8'hF1;
				16'h2265: g = 8'hF2; 16'h2264: g = 8'hF3; 16'h2320: g = 8'hF4;
				16'h2321: g = 8'hF5; 16'h00F7: g = 8'hF6; 16'h2248: g = 8'hF7;
				16'h00B0: g = 8'hF8; 16'h2219: g = 8'hF9; 16'h00B7: g = 8'hFA;
				16'h221A: g = 8'hFB; 16'h207F: g = 8'hFC; 16'h00B2: g = 8'hFD;
				16'h25A0: g = 8'hFE; 16'h00A0: g = 8'hFF;
				default: g = cp[7:0];
			endcase
		end
		return g;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/irc_art_text_cell_parser_unit.sv
// Top level of the IRC art text cell parser.
// Input channel: one text byte per word on text_byte, with in_valid/in_ready.
// Output channel: one cell or line-end word per result, with out_valid/out_ready.
// Some bytes (color codes, UTF-8 lead and middle bytes) produce no word.
// Configuration: cfg_we writes cfg_data into register cfg_index; the user
// is to write only while idle, which the block itself does not enforce.
// One byte is accepted every cycle while the queue has room; the parser state
// is updated in the accepting cycle and a result is registered at its end.
// The queue holds four words; in_ready drops when it could overflow, so a
// stalled receiver backs up through the queue to the input channel.
// After the row limit is reached, all bytes are taken and dropped until reset.
// Reset clears the parser to plain text, colors 1 on 0, column and row zero,
// and the registers to row limit 30, fix-up on, white/black palette entries.
`default_nettype none
module irc_art_text_cell_parser_unit #(
	parameter int MAX_COLUMNS = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  text_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       event_kind,
	output logic [7:0]       glyph_code,
	output logic             glyph_bank,
	output logic [9:0]       cell_column,
	output logic [7:0]       cell_row,
	output logic [23:0]      fg_rgb,
	output logic [23:0]      bg_rgb,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [23:0] cfg_data
);
	import icp_pkg::*;

	cfg_t       cfg_q;
	logic       in_fire, screen_full, word_valid, q_pop, q_ne;
	cell_word_t word, q_word;
	logic [2:0] q_cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.row_limit <= 8'd30; cfg_q.use_default <= 1'b0;
			cfg_q.pal0 <= 24'hFFFFFF; cfg_q.pal1 <= 24'h000000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROW_LIMIT:   cfg_q.row_limit <= cfg_data[7:0];
				REG_USE_DEFAULT: cfg_q.use_default <= cfg_data[0];
				REG_PAL0:        cfg_q.pal0 <= cfg_data;
				REG_PAL1:        cfg_q.pal1 <= cfg_data;
				default: ;
			endcase
		end
	end

	// The word register before the queue counts toward occupancy.
	assign in_ready = ({1'b0, q_cnt} + {3'd0, word_valid}) < 4'd3;
	assign in_fire = in_valid && in_ready;

	icp_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
		.clk, .arst_n, .in_fire, .text_byte, .row_limit(cfg_q.row_limit),
		.screen_full, .word_valid, .word
	);

	icp_queue u_queue (
		.clk, .arst_n, .wr_en(word_valid), .wr_word(word), .rd_en(q_pop),
		.rd_word(q_word), .not_empty(q_ne), .count(q_cnt)
	);

	icp_back u_back (
		.clk, .arst_n, .cfg(cfg_q), .q_valid(q_ne), .q_word, .q_pop,
		.out_valid, .out_ready, .event_kind, .glyph_code, .glyph_bank,
		.cell_column, .cell_row, .fg_rgb, .bg_rgb
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		word_valid |-> q_cnt != 3'd4) else $error("queue overflow");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_ne) else $error("pop from empty queue");
	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		screen_full |=> screen_full) else $error("screen full cleared");
	a_no_word_full: assert property (@(posedge clk) disable iff (!arst_n)
		$past(screen_full) |-> !word_valid) else $error("word after screen full");
endmodule
`default_nettype wire

FILE: hw/rtl/icp_front.sv
// Front part: parses bytes, tracks colors, UTF-8 and cursor, emits cell words.
`default_nettype none
module icp_front #(
	parameter int MAX_COLUMNS = 1024
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_fire,
	input  wire logic [7:0]        text_byte,
	input  wire logic [7:0]        row_limit,
	output logic                   screen_full,
	output logic                   word_valid,
	output icp_pkg::cell_word_t    word
);
	import icp_pkg::*;

	localparam int CW = $clog2(MAX_COLUMNS);
	localparam logic [CW-1:0] COL_MAX = CW'(MAX_COLUMNS - 1);

	typedef enum logic [3:0] {
		M_TEXT = 4'b0001,
		M_FG   = 4'b0010,
		M_BG   = 4'b0100,
		M_UTF  = 4'b1000
	} mode_t;

	mode_t        mode_q, mode_d;
	logic [1:0]   dcnt_q, dcnt_d;
	logic [6:0]   fg_q, fg_d, bg_q, bg_d;
	logic [2:0]   ulen_q, ulen_d, urcv_q, urcv_d;
	logic [7:0]   ub0_q, ub1_q, ub2_q;
	logic [CW-1:0] col_q, col_d;
	logic [7:0]   row_q, row_d;
	logic         full_q, full_d;
	logic         emit;
	cell_word_t   w;

	logic [7:0]   c;
	logic         is_digit;
	logic [3:0]   dig;
	logic [2:0]   lead_len;
	logic [7:0]   fg_mul, bg_mul;
	logic [2:0]   urcv_inc;
	logic [20:0]  cp;
	logic         text_path;
	logic [7:0]   row_inc;

	always_comb begin
		c = (text_byte < CH_SPACE) ? CH_SPACE : text_byte;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		dig = c[3:0];
		if ((c & 8'hE0) == 8'hC0) lead_len = 3'd2;
		else if ((c & 8'hF0) == 8'hE0) lead_len = 3'd3;
		else if ((c & 8'hF8) == 8'hF0) lead_len = 3'd4;
		else lead_len = 3'd0;
		fg_mul = ((dcnt_q == 2'd0) ? 8'd0 : ({1'b0, fg_q} * 8'd10)) + {4'd0, dig};
		bg_mul = ((dcnt_q == 2'd0) ? 8'd0 : ({1'b0, bg_q} * 8'd10)) + {4'd0, dig};
		urcv_inc = urcv_q + 3'd1;
		case (ulen_q)
			3'd2: cp = {10'd0, ub0_q[4:0], c[5:0]};
			3'd3: cp = {5'd0, ub0_q[3:0], ub1_q[5:0], c[5:0]};
			default: cp = {ub0_q[2:0], ub1_q[5:0], ub2_q[5:0], c[5:0]};
		endcase
		row_inc = (row_q < 8'd255) ? row_q + 8'd1 : row_q;
	end

	always_comb begin
		mode_d = mode_q; dcnt_d = dcnt_q; fg_d = fg_q; bg_d = bg_q;
		ulen_d = ulen_q; urcv_d = urcv_q; col_d = col_q; row_d = row_q;
		full_d = full_q; emit = 1'b0; text_path = 1'b0;
		w = '0;
		w.row = row_q;
		w.column = (col_q > CW'(1023)) ? 10'd1023 : 10'(col_q);
		if (in_fire && !full_q) begin
			if (text_byte == CH_CR) begin
				emit = 1'b1;
				w.column = '0;
				fg_d = 7'd1; bg_d = 7'd0; col_d = '0; mode_d = M_TEXT; dcnt_d = 2'd0;
				row_d = row_inc;
				if (row_inc >= row_limit) begin
					full_d = 1'b1; w.kind = KIND_EOL_FUL;
				end else begin
					w.kind = KIND_EOL;
				end
			end else if (text_byte == CH_NUL) begin
				mode_d = M_TEXT; dcnt_d = 2'd0;
			end else if (text_byte == CH_REV) begin
				mode_d = M_TEXT; fg_d = 7'd0; bg_d = 7'd1;
			end else if (text_byte == CH_COLOR) begin
				mode_d = M_FG; dcnt_d = 2'd0;
			end else if (text_byte == CH_PLAIN) begin
				mode_d = M_TEXT; fg_d = 7'd1; bg_d = 7'd0;
			end else if (text_byte == CH_UNDER || text_byte == CH_BOLD ||
					text_byte == CH_ITAL) begin
				mode_d = M_TEXT;
			end else begin
				case (mode_q)
					M_FG: begin
						if (is_digit && dcnt_q == 2'd2) begin
							mode_d = M_TEXT; text_path = 1'b1;
						end else if (is_digit) begin
							dcnt_d = dcnt_q + 2'd1;
							fg_d = (fg_mul > 8'd99) ? 7'd1 : fg_mul[6:0];
						end else if (c == CH_COMMA) begin
							dcnt_d = 2'd0; mode_d = M_BG;
						end else begin
							if (dcnt_q == 2'd0) begin
								fg_d = 7'd1; bg_d = 7'd0;
							end
							mode_d = M_TEXT; text_path = 1'b1;
						end
					end
					M_BG: begin
						if (is_digit) begin
							bg_d = (bg_mul > 8'd99) ? 7'd0 : bg_mul[6:0];
							dcnt_d = dcnt_q + 2'd1;
							if (dcnt_q != 2'd0) mode_d = M_TEXT;
						end else begin
							mode_d = M_TEXT; text_path = 1'b1;
						end
					end
					M_UTF: begin
						urcv_d = urcv_inc;
						if (urcv_inc >= ulen_q) begin
							mode_d = M_TEXT; emit = 1'b1;
							w.fg_idx = fg_q; w.bg_idx = bg_q;
							if (cp >= BLOCK_LO && cp <= BLOCK_HI) begin
								w.glyph = 8'(cp - BLOCK_LO); w.bank = 1'b1;
							end else begin
								w.glyph = to_cp437(cp);
							end
						end
					end
					default: text_path = 1'b1;
				endcase
				if (text_path) begin
					dcnt_d = 2'd0;
					if (lead_len != 3'd0) begin
						ulen_d = lead_len; urcv_d = 3'd1; mode_d = M_UTF;
					end else begin
						emit = 1'b1; w.glyph = c;
						w.fg_idx = fg_d; w.bg_idx = bg_d;
					end
				end
				if (emit && col_q < COL_MAX) col_d = col_q + CW'(1);
			end
		end
	end

	// Continuation bytes land at their position; the last one is used directly.
	// Other control bytes arrive here as spaces and are stored like any byte.
	always_ff @(posedge clk) begin
		if (in_fire && !full_q && text_byte != CH_CR) begin
			if (text_path && lead_len != 3'd0) ub0_q <= c;
			if (mode_q == M_UTF) begin
				if (urcv_q[1:0] == 2'd1) ub1_q <= c;
				if (urcv_q[1:0] == 2'd2) ub2_q <= c;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_TEXT; dcnt_q <= 2'd0; fg_q <= 7'd1; bg_q <= 7'd0;
			ulen_q <= 3'd0; urcv_q <= 3'd0; col_q <= '0; row_q <= 8'd0;
			full_q <= 1'b0; word_valid <= 1'b0;
		end else begin
			mode_q <= mode_d; dcnt_q <= dcnt_d; fg_q <= fg_d; bg_q <= bg_d;
			ulen_q <= ulen_d; urcv_q <= urcv_d; col_q <= col_d; row_q <= row_d;
			full_q <= full_d; word_valid <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) word <= w;
	end

	assign screen_full = full_q;
endmodule
`default_nettype wire

FILE: hw/rtl/icp_queue.sv
// Short word queue between the front and back parts.
`default_nettype none
module icp_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire icp_pkg::cell_word_t wr_word,
	input  wire logic              rd_en,
	output icp_pkg::cell_word_t    rd_word,
	output logic                   not_empty,
	output logic [2:0]             count
);
	import icp_pkg::*;

	cell_word_t  mem_q [4];
	logic [1:0]  wp_q, rp_q;
	logic [2:0]  cnt_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wp_q] <= wr_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 2'd0; rp_q <= 2'd0; cnt_q <= 3'd0;
		end else begin
			if (wr_en) wp_q <= wp_q + 2'd1;
			if (rd_en) rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, wr_en} - {2'd0, rd_en};
		end
	end

	assign rd_word = mem_q[rp_q];
	assign not_empty = (cnt_q != 3'd0);
	assign count = cnt_q;
endmodule
`default_nettype wire

FILE: hw/rtl/icp_back.sv
// Back part: color fix-up, palette lookup and the output register.
`default_nettype none
module icp_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire icp_pkg::cfg_t     cfg,
	input  wire logic              q_valid,
	input  wire icp_pkg::cell_word_t q_word,
	output logic                   q_pop,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             event_kind,
	output logic [7:0]             glyph_code,
	output logic                   glyph_bank,
	output logic [9:0]             cell_column,
	output logic [7:0]             cell_row,
	output logic [23:0]            fg_rgb,
	output logic [23:0]            bg_rgb
);
	import icp_pkg::*;

	logic [6:0]  fg, bg;
	logic [23:0] fg_c, bg_c;

	function automatic logic [23:0] lookup(input logic [6:0] i, input cfg_t k);
		logic [23:0] r;
		if (i == 7'd0 || i == 7'd99) r = k.pal0;
		else if (i == 7'd1) r = k.pal1;
		else r = pal_fixed(i);
		return r;
	endfunction

	always_comb begin
		fg = q_word.fg_idx; bg = q_word.bg_idx;
		if (fg == bg && !cfg.use_default && (bg == 7'd0 || bg == 7'd1)) begin
			fg = 7'd1; bg = 7'd0;
		end
		if (q_word.kind == KIND_GLYPH) begin
			fg_c = lookup(fg, cfg); bg_c = lookup(bg, cfg);
		end else begin
			fg_c = '0; bg_c = '0;
		end
	end

	assign q_pop = q_valid && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (!out_valid || out_ready) out_valid <= q_valid;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			event_kind <= q_word.kind; glyph_code <= q_word.glyph;
			glyph_bank <= q_word.bank; cell_column <= q_word.column;
			cell_row <= q_word.row; fg_rgb <= fg_c; bg_rgb <= bg_c;
		end
	end
endmodule
`default_nettype wire
